/* rtl/swa_pkg.sv */
// shared types and constants for the spike window amplitude block
package swa_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int AMP_W    = 17;
    localparam int IDX_W    = 10;
    localparam int DIDX_W   = 11;
    localparam int MODE_W   = 2;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 10;
    localparam int OUT_DW   = 64;

    // measurement modes
    localparam logic [MODE_W-1:0] MODE_PEAK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIFF  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FIRST  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SECOND = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [AMP_W-1:0]    t_amp;
    typedef logic        [IDX_W-1:0]    t_index;
    typedef logic signed [DIDX_W-1:0]   t_didx;

endpackage

/* rtl/spike_window_amplitude.sv */
// spike window amplitude measurement, top level
// a word is registered at the input, then the spike state and the result
// register are updated from the input register
// throughput: one sample per cycle, but the last sample of a spike waits in the
// input register while the result register holds a result not yet taken
// reset: synchronous active-low i_rst_n clears configuration registers, spike state and valids
module spike_window_amplitude #(
    parameter int MAX_SPIKE_LEN = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [swa_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [swa_pkg::CFG_DW-1:0]   i_cfg_data,
    // sample stream in
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [swa_pkg::SAMPLE_W-1:0] i_s_tdata,   // [15:0] sample
    input  logic                         i_s_tlast,   // last_sample
    // result stream out
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [16:0] amplitude, [32:17] window_max, [48:33] window_min,
    // [59:49] min_minus_max_index, [63:60] zero
    output logic [swa_pkg::OUT_DW-1:0]   o_m_tdata,
    output logic                         o_m_tuser    // window_incomplete
);
    import swa_pkg::*;

    localparam int PW = $clog2(MAX_SPIKE_LEN + 1);
    localparam int CW = (PW > IDX_W) ? PW : IDX_W;
    localparam logic [CW-1:0] POS_LIMIT = CW'(MAX_SPIKE_LEN);

    // configuration registers
    logic [MODE_W-1:0] r_mode;
    t_index            r_first;
    t_index            r_second;

    // input stage
    logic    r_in_valid;
    t_sample r_sample;
    logic    r_in_last;

    // spike state
    logic [PW-1:0] r_pos;
    t_sample       r_max;
    t_sample       r_min;
    t_index        r_max_pos;
    t_index        r_min_pos;
    t_sample       r_fpv;
    logic [1:0]    r_seen;

    // result register
    logic    r_out_valid;
    t_amp    r_amp;
    t_sample r_out_max;
    t_sample r_out_min;
    t_didx   r_out_didx;
    logic    r_out_inc;

    // next values
    logic [PW-1:0] n_pos;
    t_sample       n_max;
    t_sample       n_min;
    t_index        n_max_pos;
    t_index        n_min_pos;
    t_sample       n_fpv;
    logic [1:0]    n_seen;
    t_amp          n_amp;
    t_sample       n_out_max;
    t_sample       n_out_min;
    t_didx         n_out_didx;
    logic          n_out_inc;

    logic          out_free;
    logic          stage_fire;
    logic          in_fire;
    logic [MODE_W-1:0] mode;
    logic [CW-1:0] p_ext;
    logic [CW-1:0] first_ext;
    logic [CW-1:0] second_ext;
    logic [CW-1:0] end_ext;
    logic          complete;

    // handshakes
    assign out_free    = !r_out_valid || i_m_tready;
    assign stage_fire  = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready  = !r_in_valid || stage_fire;
    assign in_fire     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PEAK;
            r_first  <= '0;
            r_second <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_FIRST:  r_first  <= i_cfg_data[IDX_W-1:0];
                REG_SECOND: r_second <= i_cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample  <= t_sample'(i_s_tdata);
            r_in_last <= i_s_tlast;
        end
    end

    // window compares
    assign mode       = (r_mode == MODE_SPARE) ? MODE_PEAK : r_mode;
    assign p_ext      = CW'(r_pos);
    assign first_ext  = CW'(r_first);
    assign second_ext = CW'(r_second);
    assign end_ext    = (r_second < r_first) ? first_ext : second_ext;

    // state update for the registered word
    always_comb begin
        n_pos     = r_pos;
        n_max     = r_max;
        n_min     = r_min;
        n_max_pos = r_max_pos;
        n_min_pos = r_min_pos;
        n_fpv     = r_fpv;
        n_seen    = r_seen;
        if (p_ext < POS_LIMIT) begin
            if (p_ext == first_ext) begin
                n_fpv     = r_sample;
                n_seen[0] = 1'b1;
            end
            case (mode)
                MODE_PEAK: begin
                    if (p_ext == first_ext) begin
                        n_max     = r_sample;
                        n_min     = r_sample;
                        n_max_pos = IDX_W'(p_ext);
                        n_min_pos = IDX_W'(p_ext);
                    end else if (p_ext > first_ext && p_ext <= end_ext && r_seen[0]) begin
                        if (r_sample > r_max) begin
                            n_max     = r_sample;
                            n_max_pos = IDX_W'(p_ext);
                        end else if (r_sample < r_min) begin
                            n_min     = r_sample;
                            n_min_pos = IDX_W'(p_ext);
                        end
                    end
                    if (p_ext == end_ext && n_seen[0]) begin
                        n_seen[1] = 1'b1;
                    end
                end
                MODE_DIFF: begin
                    if (p_ext == second_ext) begin
                        n_max     = r_sample;
                        n_seen[1] = 1'b1;
                    end
                end
                default: ;
            endcase
            n_pos = PW'(p_ext + CW'(1));
        end
    end

    // result for a closing word
    always_comb begin
        complete   = (mode == MODE_POINT) ? n_seen[0] : (n_seen == 2'b11);
        n_amp      = '0;
        n_out_max  = '0;
        n_out_min  = '0;
        n_out_didx = '0;
        n_out_inc  = !complete;
        if (complete) begin
            case (mode)
                MODE_PEAK: begin
                    n_amp      = t_amp'(n_max) - t_amp'(n_min);
                    n_out_max  = n_max;
                    n_out_min  = n_min;
                    n_out_didx = t_didx'({1'b0, n_min_pos}) - t_didx'({1'b0, n_max_pos});
                end
                MODE_POINT: n_amp = t_amp'(n_fpv);
                default:    n_amp = t_amp'(n_max) - t_amp'(n_fpv);
            endcase
        end
    end

    // spike state registers, cleared after the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_max     <= '0;
            r_min     <= '0;
            r_max_pos <= '0;
            r_min_pos <= '0;
            r_fpv     <= '0;
            r_seen    <= '0;
        end else if (stage_fire) begin
            if (r_in_last) begin
                r_pos     <= '0;
                r_max     <= '0;
                r_min     <= '0;
                r_max_pos <= '0;
                r_min_pos <= '0;
                r_fpv     <= '0;
                r_seen    <= '0;
            end else begin
                r_pos     <= n_pos;
                r_max     <= n_max;
                r_min     <= n_min;
                r_max_pos <= n_max_pos;
                r_min_pos <= n_min_pos;
                r_fpv     <= n_fpv;
                r_seen    <= n_seen;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (stage_fire && r_in_last) begin
            r_amp      <= n_amp;
            r_out_max  <= n_out_max;
            r_out_min  <= n_out_min;
            r_out_didx <= n_out_didx;
            r_out_inc  <= n_out_inc;
        end
    end

    // output packing
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_didx, r_out_min, r_out_max, r_amp};
    assign o_m_tuser  = r_out_inc;

endmodule

/* bench/spike_window_amplitude_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the spike window amplitude block
module spike_window_amplitude_tb;
    import swa_pkg::*;

    localparam int SPIKE_LIMIT    = 1024;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

    // result word layout
    localparam int MAX_LO  = AMP_W;
    localparam int MIN_LO  = MAX_LO + SAMPLE_W;
    localparam int DIDX_LO = MIN_LO + SAMPLE_W;
    localparam int PAD_LO  = DIDX_LO + DIDX_W;

    typedef struct {
        t_sample smp;
        logic    is_last;
    } t_sample_word;

    typedef struct {
        t_amp    amplitude;
        t_sample wmax;
        t_sample wmin;
        t_didx   didx;
        logic    incomplete;
    } t_amp_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IW-1:0]    i_cfg_index = '0;
    logic [CFG_DW-1:0]    i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [SAMPLE_W-1:0]  i_s_tdata   = '0;
    logic                 i_s_tlast   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_DW-1:0]    o_m_tdata;
    logic                 o_m_tuser;

    spike_window_amplitude i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and expectation stores
    t_sample_word sample_q[$];
    t_amp_result  expected_amps[$];
    int words_queued  = 0;
    int words_taken   = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // register copies as seen by the measurement
    logic [MODE_W-1:0] cfg_mode = MODE_PEAK;
    int cfg_first  = 0;
    int cfg_second = 0;

    // per-spike measurement state
    int spike_pos = 0;
    int peak_hi   = 0;
    int peak_lo   = 0;
    int hi_pos    = 0;
    int lo_pos    = 0;
    int first_val = 0;
    logic [1:0] seen_mask = 2'b00;

    // advance the spike measurement by one sample, queue a result on the last
    task automatic measure_sample(input t_sample smp, input logic is_last);
        int v;
        int end_pt;
        int amp;
        int mx;
        int mn;
        int di;
        logic complete;
        logic [MODE_W-1:0] mode;
        t_amp_result r;
        v      = smp;
        mode   = (cfg_mode == MODE_SPARE) ? MODE_PEAK : cfg_mode;
        end_pt = (cfg_second < cfg_first) ? cfg_first : cfg_second;
        if (spike_pos < SPIKE_LIMIT) begin
            if (spike_pos == cfg_first) begin
                first_val = v;
                seen_mask[0] = 1'b1;
            end
            if (mode == MODE_PEAK) begin
                if (spike_pos == cfg_first) begin
                    peak_hi = v;
                    peak_lo = v;
                    hi_pos  = spike_pos;
                    lo_pos  = spike_pos;
                end else if (spike_pos > cfg_first && spike_pos <= end_pt && seen_mask[0]) begin
                    // ties keep the earlier index
                    if (v > peak_hi) begin
                        peak_hi = v;
                        hi_pos  = spike_pos;
                    end else if (v < peak_lo) begin
                        peak_lo = v;
                        lo_pos  = spike_pos;
                    end
                end
                if (spike_pos == end_pt && seen_mask[0])
                    seen_mask[1] = 1'b1;
            end else if (mode == MODE_DIFF) begin
                if (spike_pos == cfg_second) begin
                    peak_hi = v;
                    seen_mask[1] = 1'b1;
                end
            end
            spike_pos++;
        end
        if (is_last) begin
            amp = 0;
            mx  = 0;
            mn  = 0;
            di  = 0;
            complete = (mode == MODE_POINT) ? seen_mask[0] : (seen_mask == 2'b11);
            if (complete) begin
                if (mode == MODE_PEAK) begin
                    mx  = peak_hi;
                    mn  = peak_lo;
                    amp = mx - mn;
                    di  = lo_pos - hi_pos;
                end else if (mode == MODE_POINT) begin
                    amp = first_val;
                end else begin
                    amp = peak_hi - first_val;
                end
            end
            r.amplitude  = amp[AMP_W-1:0];
            r.wmax       = mx[SAMPLE_W-1:0];
            r.wmin       = mn[SAMPLE_W-1:0];
            r.didx       = di[DIDX_W-1:0];
            r.incomplete = ~complete;
            expected_amps.push_back(r);
            // spike closed
            spike_pos = 0;
            peak_hi   = 0;
            peak_lo   = 0;
            hi_pos    = 0;
            lo_pos    = 0;
            first_val = 0;
            seen_mask = 2'b00;
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // sample word driver
    always @(posedge i_clk) begin
        t_sample_word nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = sample_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= nxt.smp;
                i_s_tlast  <= nxt.is_last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: results first, then newly accepted samples, then the watchdog
    always @(posedge i_clk) begin
        t_amp_result e;
        logic busy;
        busy = 1'b0;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            busy = 1'b1;
            if (expected_amps.size() == 0) begin
                $display("%0t: result word with none expected, actual tdata %h tuser %b",
                         $time, o_m_tdata, o_m_tuser);
                mismatches++;
            end else begin
                e = expected_amps.pop_front();
                check_field("amplitude", e.amplitude, t_amp'(o_m_tdata[0 +: AMP_W]));
                check_field("window_max", e.wmax, t_sample'(o_m_tdata[MAX_LO +: SAMPLE_W]));
                check_field("window_min", e.wmin, t_sample'(o_m_tdata[MIN_LO +: SAMPLE_W]));
                check_field("min_minus_max_index", e.didx,
                            t_didx'(o_m_tdata[DIDX_LO +: DIDX_W]));
                check_field("window_incomplete", e.incomplete, o_m_tuser);
                check_field("tdata padding", 0, o_m_tdata[OUT_DW-1:PAD_LO]);
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            busy = 1'b1;
            measure_sample(t_sample'(i_s_tdata), i_s_tlast);
            words_taken++;
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            busy = 1'b1;
        idle_cycles = busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:   cfg_mode   = val[MODE_W-1:0];
            REG_FIRST:  cfg_first  = int'(val);
            REG_SECOND: cfg_second = int'(val);
            default: ;
        endcase
    endtask

    // mode register upper bits are don't-care, so fill them at random
    task automatic set_window(input logic [MODE_W-1:0] mode, input int first, input int second);
        logic [CFG_DW-1:0] mode_word;
        mode_word = CFG_DW'($urandom);
        mode_word[MODE_W-1:0] = mode;
        write_reg(REG_MODE, mode_word);
        write_reg(REG_FIRST, first[CFG_DW-1:0]);
        write_reg(REG_SECOND, second[CFG_DW-1:0]);
    endtask

    task automatic push_sample(input t_sample smp, input logic is_last);
        t_sample_word w;
        w.smp     = smp;
        w.is_last = is_last;
        sample_q.push_back(w);
        words_queued++;
    endtask

    // extremes and near-zero values are frequent so ties happen often
    function automatic t_sample pick_sample();
        int small_v;
        small_v = $urandom_range(6);
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return t_sample'(small_v - 3);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic push_spike(input int len);
        for (int i = 0; i < len; i++)
            push_sample(pick_sample(), i == len - 1);
    endtask

    task automatic wait_results();
        while (words_taken != words_queued || expected_amps.size() != 0)
            @(posedge i_clk);
    endtask

    // samples that close no spike may still be in the pipeline
    task automatic drain();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_point(input int span);
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1023;
            default: return $urandom_range(span);
        endcase
    endfunction

    // one register setting followed by a run of random spikes
    task automatic random_chunk(input int n_items, input logic hold_mid, input logic split);
        int first;
        int second;
        int reach;
        int len;
        int count;
        logic held;
        first  = pick_point(10);
        second = pick_point(14);
        set_window(MODE_W'($urandom_range(3)), first, second);
        reach = (second > first) ? second : first;
        count = 0;
        held  = 1'b0;
        while (count < n_items) begin
            if (reach <= 40 && $urandom_range(9) < 7)
                len = reach + 1 + $urandom_range(5);
            else
                len = $urandom_range(1, 16);
            push_spike(len);
            count += len;
            // let every pending result come back before going on
            if (hold_mid && !held && count >= n_items / 2) begin
                wait_results();
                held = 1'b1;
            end
        end
        // leave a spike open across the next register change
        if (split) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                push_sample(pick_sample(), 1'b0);
        end
        drain();
    endtask

    initial begin
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 56, 0, 23};
        stall_set = '{0, 0, 56, 23};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // peak to peak at full scale, ties on both max and min
        set_window(MODE_PEAK, 1, 4);
        push_sample(16'sd5, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd0, 1'b1);
        // spike closes before the window opens
        push_sample(16'sd9, 1'b1);
        drain();
        // reversed window collapses to the first point
        set_window(MODE_PEAK, 3, 1);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd2, 1'b0);
        push_sample(16'sd3, 1'b0);
        push_sample(-16'sd7, 1'b1);
        drain();
        // point value taken on the last sample
        set_window(MODE_POINT, 2, 0);
        push_sample(16'sd11, 1'b0);
        push_sample(16'sd22, 1'b0);
        push_sample(16'sh8000, 1'b1);
        drain();
        // difference with the later point before the first one
        set_window(MODE_DIFF, 3, 0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd2, 1'b0);
        push_sample(16'sh7FFF, 1'b1);
        drain();
        // spare mode measures as peak to peak
        set_window(MODE_SPARE, 0, 0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(-16'sd1, 1'b1);
        drain();
        // unused register index is ignored
        write_reg(REG_UNUSED, '1);
        // difference spike too short for the end point
        set_window(MODE_DIFF, 0, 5);
        push_sample(16'sd4, 1'b0);
        push_sample(16'sd5, 1'b0);
        push_sample(16'sd6, 1'b1);
        drain();

        // random spikes under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            for (int c = 0; c < 4; c++)
                random_chunk(50, c == 1, (ph != 3 || c != 3) && $urandom_range(2) == 0);
        end

        // spike longer than the tracked length, window at the far end
        set_window(MODE_PEAK, 1000, 1023);
        push_spike(SPIKE_LIMIT + 6);
        drain();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* files.f */
rtl/swa_pkg.sv
rtl/spike_window_amplitude.sv
bench/spike_window_amplitude_tb.sv
